// ----- hdl/utf8_label_validator_defines.svh -----
// assertion macros for the utf8 label validator
`ifndef UTF8_LABEL_VALIDATOR_DEFINES_SVH
`define UTF8_LABEL_VALIDATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during rst
`define ULV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, off during rst
`define ULV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ULV_ASSERT_IMP(lbl, ante, cons, msg)
`define ULV_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/ulv_pkg.sv -----
// types and constants shared by the utf8 label validator
`timescale 1ns / 1ps
`default_nettype none

package ulv_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] MAX_LENGTH_RESET = 16'd128;

  // byte classes
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] DEL_BYTE = 8'h7f;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_SURR = 8'hed;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hbf;
  localparam logic [7:0] LIM_A0 = 8'ha0;
  localparam logic [7:0] LIM_9F = 8'h9f;
  localparam logic [7:0] LIM_90 = 8'h90;
  localparam logic [7:0] LIM_8F = 8'h8f;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_MIN_A0,
    RULE_MAX_9F,
    RULE_MIN_90,
    RULE_MAX_8F
  } rule_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic                accepted;
    logic [LEN_BITS-1:0] label_length;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/ulv_in_reg.sv -----
// input register stage of the utf8 label validator
`timescale 1ns / 1ps
`default_nettype none

module ulv_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ulv_pkg::in_word_t in_data,
  input  wire logic             take,
  output logic                  s_valid,
  output ulv_pkg::in_word_t     s_word
);

  assign in_ready = !s_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (take) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_word <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ulv_check.sv -----
// label state and per-byte utf8 check of the utf8 label validator
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_label_validator_defines.svh"

module ulv_check #(
  parameter int COUNT_BITS = ulv_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ulv_pkg::LEN_BITS-1:0]  cfg_data,
  input  wire logic                          s_valid,
  input  wire ulv_pkg::in_word_t             s_word,
  input  wire logic                          res_room,
  output logic                               take,
  output logic                               res_valid,
  output ulv_pkg::out_word_t                 res_word
);

  localparam int LB = ulv_pkg::LEN_BITS;
  localparam int WB = (COUNT_BITS > LB) ? COUNT_BITS : LB;

  logic [LB-1:0]         max_length;
  logic [1:0]            cont;
  logic [1:0]            cont_next;
  ulv_pkg::rule_t        rule;
  ulv_pkg::rule_t        rule_next;
  logic                  failed;
  logic                  failed_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  at_limit;
  logic                  byte_ok;
  logic [7:0]            b;
  logic [WB-1:0]         cnt_wide;
  logic [WB-1:0]         max_wide;
  logic                  is_final;

  assign b = s_word.text_byte;
  assign is_final = s_word.final_byte;
  assign take = s_valid && (!is_final || res_room);
  assign res_valid = s_valid && is_final && res_room;

  assign at_limit = &count;
  assign count_next = at_limit ? count : count + COUNT_BITS'(1);

  // per-byte check; state only moves on a passing byte
  always_comb begin
    byte_ok = 1'b0;
    cont_next = cont;
    rule_next = rule;
    if (cont != 2'd0) begin
      byte_ok = (b >= ulv_pkg::CONT_LO) && (b <= ulv_pkg::CONT_HI);
      case (rule)
        ulv_pkg::RULE_NONE:   ;
        ulv_pkg::RULE_MIN_A0: if (b < ulv_pkg::LIM_A0) byte_ok = 1'b0;
        ulv_pkg::RULE_MAX_9F: if (b > ulv_pkg::LIM_9F) byte_ok = 1'b0;
        ulv_pkg::RULE_MIN_90: if (b < ulv_pkg::LIM_90) byte_ok = 1'b0;
        ulv_pkg::RULE_MAX_8F: if (b > ulv_pkg::LIM_8F) byte_ok = 1'b0;
        default:              ;
      endcase
      if (byte_ok) begin
        rule_next = ulv_pkg::RULE_NONE;
        cont_next = cont - 2'd1;
      end
    end else if (b < ulv_pkg::CTRL_LIMIT || b == ulv_pkg::DEL_BYTE) begin
      byte_ok = 1'b0;
    end else if (b < ulv_pkg::ASCII_END) begin
      byte_ok = 1'b1;
    end else if (b >= ulv_pkg::LEAD2_LO && b <= ulv_pkg::LEAD2_HI) begin
      byte_ok = 1'b1;
      cont_next = 2'd1;
      rule_next = ulv_pkg::RULE_NONE;
    end else if (b >= ulv_pkg::LEAD3_LO && b <= ulv_pkg::LEAD3_HI) begin
      byte_ok = 1'b1;
      cont_next = 2'd2;
      if (b == ulv_pkg::LEAD3_LO) rule_next = ulv_pkg::RULE_MIN_A0;
      else if (b == ulv_pkg::LEAD3_SURR) rule_next = ulv_pkg::RULE_MAX_9F;
      else rule_next = ulv_pkg::RULE_NONE;
    end else if (b >= ulv_pkg::LEAD4_LO && b <= ulv_pkg::LEAD4_HI) begin
      byte_ok = 1'b1;
      cont_next = 2'd3;
      if (b == ulv_pkg::LEAD4_LO) rule_next = ulv_pkg::RULE_MIN_90;
      else if (b == ulv_pkg::LEAD4_HI) rule_next = ulv_pkg::RULE_MAX_8F;
      else rule_next = ulv_pkg::RULE_NONE;
    end
  end

  // a saturated counter or an earlier error freezes the sequence state
  assign failed_next = failed || at_limit || !byte_ok;

  assign cnt_wide = WB'(count_next);
  assign max_wide = WB'(max_length);

  always_comb begin
    res_word.accepted = !failed_next && (cont_next == 2'd0) && (cnt_wide <= max_wide);
    if (cnt_wide > WB'({LB{1'b1}})) begin
      res_word.label_length = {LB{1'b1}};
    end else begin
      res_word.label_length = cnt_wide[LB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= ulv_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cont <= 2'd0;
      rule <= ulv_pkg::RULE_NONE;
      failed <= 1'b0;
      count <= '0;
    end else if (take) begin
      if (is_final) begin
        cont <= 2'd0;
        rule <= ulv_pkg::RULE_NONE;
        failed <= 1'b0;
        count <= '0;
      end else begin
        count <= count_next;
        failed <= failed_next;
        if (!(failed || at_limit)) begin
          cont <= cont_next;
          rule <= rule_next;
        end
      end
    end
  end

  `ULV_ASSERT_IMP(a_final_waits, s_valid && is_final && !res_room, !take, "final word taken without room")
  `ULV_ASSERT_NXT(a_label_clear, take && is_final, count == '0 && cont == 2'd0 && !failed, "label state not cleared")
  `ULV_ASSERT_IMP(a_rule_idle, cont == 2'd0, rule == ulv_pkg::RULE_NONE, "narrowing rule outside a sequence")
  `ULV_ASSERT_NXT(a_count_sat, take && !is_final && at_limit, &count, "byte counter left saturation")

endmodule

`default_nettype wire

// ----- hdl/ulv_out_reg.sv -----
// result register of the utf8 label validator
`timescale 1ns / 1ps
`default_nettype none

module ulv_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               res_valid,
  input  wire ulv_pkg::out_word_t res_word,
  output logic                    res_room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ulv_pkg::out_word_t      out_data
);

  assign res_room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_word;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/utf8_label_validator.sv -----
// top level of the utf8 label validator
//
// channel   direction  handshake            word
// input     in         in_valid / in_ready  in_data: text_byte, final_byte
// result    out        out_valid/out_ready  out_data: accepted, label_length
// config    in         cfg_we               cfg_data: max_length
//
// one byte per cycle unless a final byte waits for room; each result is registered
// the check and length compare sit between the input register and the result register
// a stalled result blocks the input only once a final byte waits in the input register
// rst is synchronous: clears label state and sets max_length to 128
`timescale 1ns / 1ps
`default_nettype none

module utf8_label_validator #(
  parameter int COUNT_BITS = ulv_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ulv_pkg::LEN_BITS-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ulv_pkg::in_word_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ulv_pkg::out_word_t                out_data
);

  logic               take;
  logic               s_valid;
  ulv_pkg::in_word_t  s_word;
  logic               res_room;
  logic               res_valid;
  ulv_pkg::out_word_t res_word;

  ulv_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .s_valid  (s_valid),
    .s_word   (s_word)
  );

  ulv_check #(
    .COUNT_BITS (COUNT_BITS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .s_valid   (s_valid),
    .s_word    (s_word),
    .res_room  (res_room),
    .take      (take),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  ulv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_word  (res_word),
    .res_room  (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
